/* rtl/all_pairs_shortest_path_unit_defines.svh */
// Assertion macros shared by the all-pairs shortest path RTL.
`ifndef ALL_PAIRS_SHORTEST_PATH_UNIT_DEFINES_SVH
`define ALL_PAIRS_SHORTEST_PATH_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk and masked while rst_n is low.
`define APSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk and masked while rst_n is low.
`define APSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/apsp_pkg.sv */
// Shared constants, types and helper functions of the shortest path unit.
`default_nettype none
package apsp_pkg;

  localparam int MAX_VERTICES = 8;
  localparam int VW           = 3;                // vertex index width (port field)
  localparam int AW           = 2 * VW;           // matrix address {row, col}
  localparam int DEPTH        = 1 << AW;
  localparam int ROWS         = 1 << VW;
  localparam int DW           = 16;               // distance width
  localparam int WW           = 10;               // edge weight width
  localparam int CW           = 4;                // active_vertices width
  localparam logic [CW-1:0] CFG_RESET = CW'(8);

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_LOAD  = 3'd1,
    OP_RD_A  = 3'd2,
    OP_RD_B  = 3'd3,
    OP_UPD   = 3'd4,
    OP_EM_RD = 3'd5,
    OP_EM_LD = 3'd6
  } op_t;

  typedef struct packed {
    op_t           op;
    logic [VW-1:0] k;
    logic [VW-1:0] i;
    logic [VW-1:0] j;
    logic          last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  // Reachability after clear: diagonal only.
  function automatic logic [DEPTH-1:0] ident_reach();
    logic [DEPTH-1:0] v;
    v = '0;
    for (int r = 0; r < ROWS; r++) begin
      v[r * ROWS + r] = 1'b1;
    end
    return v;
  endfunction

  // Add two distances and clamp to the signed 16-bit range.
  function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) begin
      return s[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
    return s[DW-1:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/apsp_ctrl.sv */
// Sequencer: input and config handshakes, pivot/row/column counters, commands.
`default_nettype none
module apsp_ctrl (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_tvalid,
  output logic                      in_tready,
  input  wire                       in_mode,
  input  wire  [apsp_pkg::VW-1:0]   in_from,
  input  wire  [apsp_pkg::VW-1:0]   in_to,
  input  wire                       cfg_tvalid,
  output logic                      cfg_tready,
  input  wire  [apsp_pkg::CW-1:0]   cfg_value,
  input  wire  apsp_pkg::stat_t     stat,
  output apsp_pkg::cmd_t            cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD_A  = 6'b000010,
    S_RD_B  = 6'b000100,
    S_UPD   = 6'b001000,
    S_EM_RD = 6'b010000,
    S_EM_LD = 6'b100000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [apsp_pkg::VW-1:0] k_r, k_nxt, i_r, i_nxt, j_r, j_nxt, lim_r, lim_nxt;
  logic [apsp_pkg::CW-1:0] act_r;
  logic [apsp_pkg::CW-1:0] n_clamp;
  logic                    j_end, i_end, k_end;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_tready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= apsp_pkg::CFG_RESET;
    end else if (cfg_tvalid) begin
      act_r <= cfg_value;
    end
  end

  // Clamp the active count into 1..MAX_VERTICES.
  always_comb begin
    priority if (act_r == '0) begin
      n_clamp = apsp_pkg::CW'(1);
    end else if (act_r > apsp_pkg::CW'(apsp_pkg::MAX_VERTICES)) begin
      n_clamp = apsp_pkg::CW'(apsp_pkg::MAX_VERTICES);
    end else begin
      n_clamp = act_r;
    end
  end

  assign j_end = (j_r == lim_r);
  assign i_end = (i_r == lim_r);
  assign k_end = (k_r == lim_r);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    lim_nxt   = lim_r;
    cmd.op    = apsp_pkg::OP_NONE;
    cmd.k     = k_r;
    cmd.i     = i_r;
    cmd.j     = j_r;
    cmd.last  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && !in_mode) begin
          cmd.op = apsp_pkg::OP_LOAD;
          cmd.i  = in_from;
          cmd.j  = in_to;
        end else if (in_tvalid && in_mode) begin
          lim_nxt   = apsp_pkg::VW'(n_clamp - apsp_pkg::CW'(1));
          k_nxt     = '0;
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = S_RD_A;
        end
      end
      S_RD_A: begin
        cmd.op    = apsp_pkg::OP_RD_A;
        state_nxt = S_RD_B;
      end
      S_RD_B: begin
        cmd.op    = apsp_pkg::OP_RD_B;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.op    = apsp_pkg::OP_UPD;
        state_nxt = S_RD_A;
        if (!j_end) begin
          j_nxt = j_r + apsp_pkg::VW'(1);
        end else begin
          j_nxt = '0;
          if (!i_end) begin
            i_nxt = i_r + apsp_pkg::VW'(1);
          end else begin
            i_nxt = '0;
            if (!k_end) begin
              k_nxt = k_r + apsp_pkg::VW'(1);
            end else begin
              k_nxt     = '0;
              state_nxt = S_EM_RD;
            end
          end
        end
      end
      S_EM_RD: begin
        cmd.op    = apsp_pkg::OP_EM_RD;
        state_nxt = S_EM_LD;
      end
      S_EM_LD: begin
        if (stat.out_free) begin
          cmd.op   = apsp_pkg::OP_EM_LD;
          cmd.last = i_end && j_end;
          if (i_end && j_end) begin
            i_nxt     = '0;
            j_nxt     = '0;
            state_nxt = S_IDLE;
          end else if (j_end) begin
            j_nxt     = '0;
            i_nxt     = i_r + apsp_pkg::VW'(1);
            state_nxt = S_EM_RD;
          end else begin
            j_nxt     = j_r + apsp_pkg::VW'(1);
            state_nxt = S_EM_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      i_r     <= '0;
      j_r     <= '0;
      lim_r   <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      lim_r   <= lim_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/apsp_dpath.sv */
// Datapath: distance memory, reachability flags, saturating adder, result register.
`default_nettype none
module apsp_dpath (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire  apsp_pkg::cmd_t             cmd,
  input  wire  signed [apsp_pkg::WW-1:0]   in_weight,
  output apsp_pkg::stat_t                  stat,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [23:0]                      out_tdata,
  output logic                             out_tuser,
  output logic                             out_tlast
);

  localparam int VW = apsp_pkg::VW;
  localparam int AW = apsp_pkg::AW;
  localparam int DW = apsp_pkg::DW;

  logic signed [DW-1:0]      dist_mem [apsp_pkg::DEPTH];
  logic [apsp_pkg::DEPTH-1:0] reach_r;
  logic [apsp_pkg::ROWS-1:0]  diag_wr_r;

  logic [AW-1:0]        raddr0, raddr1, waddr;
  logic                 zero0, zero1, zero0_r, zero1_r;
  logic signed [DW-1:0] rd0_r, rd1_r, d0, d1, sum_r, wdata;
  logic                 we;
  logic                 reach_ik, reach_kj, reach_ij;

  logic                 out_valid_r;
  logic [VW-1:0]        out_row_r, out_col_r;
  logic signed [DW-1:0] out_dist_r;
  logic                 out_reach_r, out_last_r;

  // Port 0 reads the row-to-pivot leg first, then the target entry.
  assign raddr0 = (cmd.op == apsp_pkg::OP_RD_A) ? {cmd.i, cmd.k} : {cmd.i, cmd.j};
  assign raddr1 = {cmd.k, cmd.j};

  // An unwritten diagonal entry reads as zero.
  assign zero0 = (raddr0[AW-1:VW] == raddr0[VW-1:0]) && !diag_wr_r[raddr0[VW-1:0]];
  assign zero1 = (raddr1[AW-1:VW] == raddr1[VW-1:0]) && !diag_wr_r[raddr1[VW-1:0]];

  always_ff @(posedge clk) begin
    rd0_r   <= dist_mem[raddr0];
    rd1_r   <= dist_mem[raddr1];
    zero0_r <= zero0;
    zero1_r <= zero1;
  end

  assign d0 = zero0_r ? '0 : rd0_r;
  assign d1 = zero1_r ? '0 : rd1_r;

  always_ff @(posedge clk) begin
    if (cmd.op == apsp_pkg::OP_RD_B) begin
      sum_r <= apsp_pkg::sat_add(d0, d1);
    end
  end

  assign reach_ik = reach_r[{cmd.i, cmd.k}];
  assign reach_kj = reach_r[{cmd.k, cmd.j}];
  assign reach_ij = reach_r[{cmd.i, cmd.j}];
  assign waddr    = {cmd.i, cmd.j};

  always_comb begin
    we    = 1'b0;
    wdata = sum_r;
    unique case (cmd.op)
      apsp_pkg::OP_LOAD: begin
        we    = (32'(cmd.i) < apsp_pkg::MAX_VERTICES) &&
                (32'(cmd.j) < apsp_pkg::MAX_VERTICES);
        wdata = DW'(in_weight);
      end
      apsp_pkg::OP_UPD: begin
        we = reach_ik && reach_kj && (!reach_ij || (sum_r < d0));
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      dist_mem[waddr] <= wdata;
    end
  end

  // Clear back to the identity pattern with the final result beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reach_r   <= apsp_pkg::ident_reach();
      diag_wr_r <= '0;
    end else if (cmd.op == apsp_pkg::OP_EM_LD && cmd.last) begin
      reach_r   <= apsp_pkg::ident_reach();
      diag_wr_r <= '0;
    end else if (we) begin
      reach_r[waddr] <= 1'b1;
      if (cmd.i == cmd.j) begin
        diag_wr_r[cmd.i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == apsp_pkg::OP_EM_LD) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == apsp_pkg::OP_EM_LD) begin
      out_row_r   <= cmd.i;
      out_col_r   <= cmd.j;
      out_dist_r  <= reach_ij ? d0 : '0;
      out_reach_r <= reach_ij;
      out_last_r  <= cmd.last;
    end
  end

  assign stat.out_free = !out_valid_r || out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = {2'b00, out_dist_r, out_col_r, out_row_r};
  assign out_tuser     = out_reach_r;
  assign out_tlast     = out_last_r;

endmodule
`default_nettype wire

/* rtl/all_pairs_shortest_path_unit.sv */
// Top level of the Floyd-Warshall all-pairs shortest path unit.
`default_nettype none
//
//  channel | dir | beat carries
//  --------+-----+------------------------------------------------------------
//  in_     | in  | tuser mode; tdata from_vertex, to_vertex, edge_weight
//  out_    | out | tuser reachable; tlast last; tdata row, col, distance
//  cfg_    | in  | tdata active_vertices (always ready)
//
//  A load beat can be accepted every cycle while the unit is idle.
//  A solve beat starts the relaxation over the n active vertices: each
//  step reads two legs, then the target entry, from the two read ports of the
//  distance memory, then writes back. The emit then reads and loads the n*n
//  entries one by one, and stalls while out_tready is low.
//  Reset is synchronous (rst_n low); the reachable flags return to the
//  diagonal at once, so there is no clearing sweep. The same happens on the
//  final result beat, ready for the next load.
//  The result register holds a beat while out_tready is low; the sequencer
//  stalls the emit until the register frees up.
`include "all_pairs_shortest_path_unit_defines.svh"
module all_pairs_shortest_path_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // [2:0] from_vertex, [5:3] to_vertex, [15:6] edge_weight
  input  wire         in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,  // [2:0] row_vertex, [5:3] col_vertex, [21:6] distance
  output logic        out_tuser,  // [0] reachable
  output logic        out_tlast,
  input  wire         cfg_tvalid,
  output logic        cfg_tready,
  input  wire  [7:0]  cfg_tdata   // [3:0] active_vertices
);

  apsp_pkg::cmd_t  cmd;
  apsp_pkg::stat_t stat;

  apsp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_mode    (in_tuser),
    .in_from    (in_tdata[2:0]),
    .in_to      (in_tdata[5:3]),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_value  (cfg_tdata[3:0]),
    .stat       (stat),
    .cmd        (cmd)
  );

  apsp_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_weight  (in_tdata[15:6]),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Never load the result register over a beat that has not been taken.
  `APSP_ASSERT_NOW(a_no_overwrite, cmd.op == apsp_pkg::OP_EM_LD, stat.out_free, "result overwritten")
  // A solve beat makes the unit busy.
  `APSP_ASSERT_NEXT(a_solve_busy, in_tvalid && in_tready && in_tuser, !in_tready, "solve not started")
  // Loading the final entry returns the unit to idle.
  `APSP_ASSERT_NEXT(a_last_idle, cmd.op == apsp_pkg::OP_EM_LD && cmd.last, in_tready, "no idle after emit")

endmodule
`default_nettype wire

/* dv/tb_all_pairs_shortest_path_unit.sv */
// Self-checking testbench for the all-pairs shortest path unit: edge loads, solves, results.
`default_nettype none
module tb_all_pairs_shortest_path_unit;

  localparam int CLK_PERIOD = 12;

  localparam int VW           = apsp_pkg::VW;
  localparam int DW           = apsp_pkg::DW;
  localparam int WW           = apsp_pkg::WW;
  localparam int CW           = apsp_pkg::CW;
  localparam int MAX_VERTICES = apsp_pkg::MAX_VERTICES;

  // Beat kinds carried on in_tuser
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_SOLVE = 1'b1;

  // Weight mixes for random edges
  localparam int WT_ANY      = 0;
  localparam int WT_SHORT    = 1;
  localparam int WT_NEGATIVE = 2;
  localparam int WT_MIXED    = 3;

  // Settle time after the last result before touching the register, ample for
  // a load still in flight to finish.
  localparam int SETTLE_CYCLES = 8;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;    // [2:0] from_vertex, [5:3] to_vertex, [15:6] edge_weight
  logic        in_tuser;    // [0] mode
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;   // [2:0] row_vertex, [5:3] col_vertex, [21:6] distance
  logic        out_tuser;   // [0] reachable
  logic        out_tlast;
  logic        cfg_tvalid;
  logic        cfg_tready;
  logic [7:0]  cfg_tdata;   // [3:0] active_vertices

  all_pairs_shortest_path_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata)
  );

  // One entry of the emitted distance matrix
  typedef struct {
    logic [VW-1:0]        row;
    logic [VW-1:0]        col;
    logic signed [DW-1:0] len;
    logic                 reach;
    logic                 last;
  } dist_entry_t;

  // Shadow copy of the block's graph and register
  logic signed [DW-1:0] path_len [MAX_VERTICES][MAX_VERTICES];
  bit                   path_ok  [MAX_VERTICES][MAX_VERTICES];
  logic [CW-1:0]        active_setting;

  dist_entry_t awaited_entries[$];

  int error_count;
  int beats_sent;
  int edges_loaded;
  int solves_run;
  int entries_checked;
  int saturated_seen;
  int neg_diag_seen;

  // Idling controls shared with the driver and the receiver
  bit in_gaps;
  bit out_stalls;
  int hold_request;

  // ------------------------------------------------------------------
  // Clock and run limit
  // ------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Run limit; the slowest legal run stays well under it
  initial begin
    #(CLK_PERIOD * 5000000);
    $display("tb_all_pairs_shortest_path_unit: done, errors");
    $finish;
  end

  // ------------------------------------------------------------------
  // Graph predictor
  // ------------------------------------------------------------------
  function automatic void clear_graph();
    for (int r = 0; r < MAX_VERTICES; r++) begin
      for (int c = 0; c < MAX_VERTICES; c++) begin
        path_len[r][c] = '0;
        path_ok[r][c]  = (r == c);
      end
    end
  endfunction

  function automatic int active_count(input logic [CW-1:0] setting);
    if (setting < 1) return 1;
    if (setting > MAX_VERTICES) return MAX_VERTICES;
    return int'(setting);
  endfunction

  // Apply one accepted beat to the shadow graph; a solve relaxes in place
  // (pivot, row, column), queues the n*n entries it will emit, then clears.
  task automatic apply_graph_beat(input logic mode, input logic [VW-1:0] src,
                                  input logic [VW-1:0] dst, input logic [WW-1:0] w);
    int nv;
    int leg_a;
    int leg_b;
    int sum;
    dist_entry_t e;
    if (mode == MODE_LOAD) begin
      path_len[src][dst] = $signed(w);
      path_ok[src][dst]  = 1'b1;
      edges_loaded++;
    end else begin
      nv = active_count(active_setting);
      for (int k = 0; k < nv; k++) begin
        for (int i = 0; i < nv; i++) begin
          if (!path_ok[i][k]) continue;
          for (int j = 0; j < nv; j++) begin
            if (!path_ok[k][j]) continue;
            leg_a = path_len[i][k];
            leg_b = path_len[k][j];
            sum   = leg_a + leg_b;
            if (sum > 32767) sum = 32767;
            if (sum < -32768) sum = -32768;
            if (!path_ok[i][j] || sum < int'(path_len[i][j])) begin
              path_len[i][j] = DW'(sum);
              path_ok[i][j]  = 1'b1;
            end
          end
        end
      end
      for (int i = 0; i < nv; i++) begin
        for (int j = 0; j < nv; j++) begin
          e.row   = VW'(i);
          e.col   = VW'(j);
          e.reach = path_ok[i][j];
          e.len   = path_ok[i][j] ? path_len[i][j] : '0;
          e.last  = (i == nv - 1) && (j == nv - 1);
          awaited_entries.insert(awaited_entries.size(), e);
        end
      end
      clear_graph();
      solves_run++;
    end
  endtask

  // ------------------------------------------------------------------
  // Result checker: compare every accepted beat with the oldest entry
  // ------------------------------------------------------------------
  dist_entry_t want;
  dist_entry_t got;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.row   = out_tdata[2:0];
      got.col   = out_tdata[5:3];
      got.len   = out_tdata[21:6];
      got.reach = out_tuser;
      got.last  = out_tlast;
      if (awaited_entries.size() == 0) begin
        $display("%0t: unexpected result beat: expected none", $time);
        $display("%0t:   actual row %0d col %0d len %0d reach %0b last %0b",
                 $time, got.row, got.col, got.len, got.reach, got.last);
        error_count++;
      end else begin
        want = awaited_entries.pop_front();
        entries_checked++;
        if (want.reach && want.len == -32768) saturated_seen++;
        if (want.reach && want.row == want.col && want.len < 0) neg_diag_seen++;
        if (got.row !== want.row || got.col !== want.col || got.len !== want.len ||
            got.reach !== want.reach || got.last !== want.last) begin
          $display("%0t: result mismatch: expected row %0d col %0d len %0d reach %0b last %0b",
                   $time, want.row, want.col, want.len, want.reach, want.last);
          $display("%0t:                  actual row %0d col %0d len %0d reach %0b last %0b",
                   $time, got.row, got.col, got.len, got.reach, got.last);
          error_count++;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Result receiver: random stall bursts, plus a long hold on request
  // ------------------------------------------------------------------
  initial begin
    int hold_left;
    forever begin
      if (hold_request > 0) begin
        // Hold off for the requested stretch, counted here cycle by cycle
        out_tready <= 1'b0;
        hold_left = hold_request;
        hold_request = 0;
        while (hold_left > 0) begin
          @(posedge clk);
          hold_left--;
        end
      end else if (out_stalls && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ------------------------------------------------------------------
  // Driver tasks
  // ------------------------------------------------------------------

  // Offer one beat, hold it until accepted, then record it in the predictor.
  // Valid stays high afterwards unless an idle burst follows; the caller
  // drops it with end_burst after its final beat.
  task automatic send_beat(input logic mode, input logic [VW-1:0] src,
                           input logic [VW-1:0] dst, input logic [WW-1:0] w);
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {w, dst, src};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_graph_beat(mode, src, dst, w);
    beats_sent++;
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic end_burst();
    in_tvalid <= 1'b0;
  endtask

  task automatic load_edge(input int src, input int dst, input int weight);
    send_beat(MODE_LOAD, VW'(src), VW'(dst), WW'(weight));
  endtask

  // Solve beats carry random junk in the edge fields
  task automatic solve_graph();
    send_beat(MODE_SOLVE, VW'($urandom), VW'($urandom), WW'($urandom));
  endtask

  // Wait for every awaited entry, then let a load still in flight finish
  task automatic drain_and_settle();
    while (awaited_entries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write active_vertices; only ever called with the block idle
  task automatic write_active(input logic [CW-1:0] setting);
    drain_and_settle();
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= {4'b0, setting};
    @(posedge clk);
    while (!cfg_tready) @(posedge clk);
    cfg_tvalid <= 1'b0;
    active_setting = setting;
  endtask

  function automatic logic [WW-1:0] pick_weight(input int style);
    case (style)
      WT_ANY:      return WW'($urandom_range(0, 1023));
      WT_SHORT:    return WW'($urandom_range(0, 60));
      WT_NEGATIVE: return WW'(-int'($urandom_range(1, 512)));
      default:     return ($urandom_range(0, 1) == 1) ? WW'($urandom_range(0, 200))
                                                      : WW'(-int'($urandom_range(1, 40)));
    endcase
  endfunction

  // One random graph: set the active count, load a handful of edges (a few
  // beyond the active square), then solve, sometimes twice in a row.
  task automatic run_graph_phase(input logic [CW-1:0] setting, input int style);
    int nv;
    int n_loads;
    int src;
    int dst;
    write_active(setting);
    nv = active_count(setting);
    n_loads = $urandom_range(0, 2 * nv + 2);
    for (int s = 0; s < n_loads; s++) begin
      src = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(0, nv - 1);
      dst = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(0, nv - 1);
      send_beat(MODE_LOAD, VW'(src), VW'(dst), pick_weight(style));
    end
    solve_graph();
    if ($urandom_range(0, 5) == 0) solve_graph();
    end_burst();
  endtask

  // Complete graph of negative edges: deep negative cycles, saturating sums
  task automatic run_dense_negative(input int nv);
    write_active(CW'(nv));
    for (int i = 0; i < nv; i++) begin
      for (int j = 0; j < nv; j++) begin
        send_beat(MODE_LOAD, VW'(i), VW'(j), pick_weight(WT_NEGATIVE));
      end
    end
    solve_graph();
    end_burst();
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Solve straight after reset: eight vertices, identity reachability
  task automatic test_empty_graph();
    solve_graph();
    end_burst();
  endtask

  // Overwrite, weight extremes, self loops, negative cycle, edges outside
  // the active square, then a second solve to prove the clear
  task automatic test_edge_cases();
    write_active(CW'(4));
    load_edge(0, 1, 511);
    load_edge(0, 1, -512);     // overwrites the previous edge
    load_edge(1, 0, 300);      // closes a negative cycle through 0 and 1
    load_edge(2, 2, -5);       // negative self loop
    load_edge(3, 3, 511);      // positive self loop replaces the zero diagonal
    load_edge(1, 3, 7);
    load_edge(7, 7, 100);      // outside the active square: stored, unused
    load_edge(7, 0, -200);
    load_edge(0, 7, 42);
    solve_graph();
    end_burst();
    write_active(CW'(8));
    solve_graph();             // matrix must be back to identity
    end_burst();
  endtask

  // active_vertices below and above its legal range
  task automatic test_active_limits();
    write_active(CW'(0));      // clamps to one vertex
    load_edge(0, 0, -1);
    solve_graph();
    end_burst();
    write_active(CW'(15));     // clamps to eight
    load_edge(7, 0, 100);
    solve_graph();
    end_burst();
    write_active(CW'(1));
    solve_graph();
    end_burst();
  endtask

  // Three vertices fully connected at the most negative weight
  task automatic test_saturation();
    write_active(CW'(3));
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        load_edge(i, j, -512);
      end
    end
    solve_graph();
    end_burst();
  endtask

  // Hold the receiver off across a solve while loads keep coming, so the
  // result register fills and the input side stalls behind it
  task automatic test_back_pressure();
    in_gaps = 1'b0;
    write_active(CW'(3));
    load_edge(0, 1, 5);
    load_edge(1, 2, 6);
    hold_request = 400;
    solve_graph();
    for (int s = 0; s < 10; s++) begin
      send_beat(MODE_LOAD, VW'($urandom_range(0, 2)), VW'($urandom_range(0, 2)),
                pick_weight(WT_MIXED));
    end
    solve_graph();
    end_burst();
    in_gaps = 1'b1;
  endtask

  task automatic test_random_graphs();
    int first_beat;
    int pick;
    logic [CW-1:0] setting;
    first_beat = beats_sent;
    while (beats_sent - first_beat < 160) begin
      // Vary idling per phase so some phases run at full rate
      in_gaps    = ($urandom_range(0, 4) != 0);
      out_stalls = ($urandom_range(0, 4) != 0);
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        run_dense_negative($urandom_range(3, 4));
      end else begin
        if (pick < 14)      setting = CW'($urandom_range(1, 5));
        else if (pick < 17) setting = CW'($urandom_range(6, 8));
        else if (pick < 18) setting = CW'(0);
        else                setting = CW'($urandom_range(9, 15));
        run_graph_phase(setting, $urandom_range(WT_ANY, WT_MIXED));
      end
    end
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_steady_tail();
    in_gaps    = 1'b0;
    out_stalls = 1'b0;
    run_graph_phase(CW'(4), WT_MIXED);
    run_graph_phase(CW'(8), WT_ANY);
    run_graph_phase(CW'(2), WT_SHORT);
  endtask

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------
  initial begin
    error_count     = 0;
    beats_sent      = 0;
    edges_loaded    = 0;
    solves_run      = 0;
    entries_checked = 0;
    saturated_seen  = 0;
    neg_diag_seen   = 0;
    in_gaps         = 1'b1;
    out_stalls      = 1'b1;
    hold_request    = 0;
    active_setting  = apsp_pkg::CFG_RESET;
    clear_graph();

    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= MODE_LOAD;
    cfg_tvalid <= 1'b0;
    cfg_tdata  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_graph();
    test_edge_cases();
    test_active_limits();
    test_saturation();
    test_back_pressure();
    test_random_graphs();
    test_steady_tail();

    // Drain the last matrix, then give the block time to show any stray beat
    while (awaited_entries.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Covered %0d edge loads and %0d solves; %0d matrix entries compared,",
             edges_loaded, solves_run, entries_checked);
    $display("of them %0d saturated and %0d negative diagonal entries.",
             saturated_seen, neg_diag_seen);
    if (error_count == 0) begin
      $display("tb_all_pairs_shortest_path_unit: done, clean");
    end else begin
      $display("tb_all_pairs_shortest_path_unit: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
